>>> src/tsft_pkg.sv
`timescale 1ns / 1ps

package tsft_pkg;

   // field widths fixed by the interface
   localparam int TIME_BITS_DEF = 48;
   localparam int LEN_BITS      = 31;
   localparam int SLOT_BITS     = 8;
   localparam int KIND_BITS     = 3;
   localparam int CSR_IDX_BITS  = 2;

   // item kinds
   localparam logic [KIND_BITS-1:0] KIND_SET_START = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_PREAMBLE  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_RESTART   = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_IDLE      = 3'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_LENGTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOT_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INITIAL_WAIT = 2'd2;

   // configuration reset values
   localparam logic [LEN_BITS-1:0] FRAME_LENGTH_RST = 31'd1000000;
   localparam logic [LEN_BITS-1:0] SLOT_LENGTH_RST  = 31'd100000;
   localparam logic [LEN_BITS-1:0] INITIAL_WAIT_RST = 31'd0;

   localparam logic [SLOT_BITS-1:0] SLOT_MAX = 8'd255;

   // zero length acts as one
   function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] v);
      eff_len = (v == '0) ? LEN_BITS'(1) : v;
   endfunction

   // slot number from a slot quotient, 1-based, saturating
   function automatic logic [SLOT_BITS-1:0] slot_sat(input logic [LEN_BITS-1:0] q);
      slot_sat = (q >= LEN_BITS'(SLOT_MAX)) ? SLOT_MAX : (q[SLOT_BITS-1:0] + 8'd1);
   endfunction

endpackage

>>> src/tsft_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module tsft_div import tsft_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS-1:0] dividend,
   input  logic [LEN_BITS-1:0]  divisor,
   output logic                 done,
   output logic [TIME_BITS-1:0] quot,
   output logic [LEN_BITS-1:0]  rem
);

   localparam int CW = $clog2(TIME_BITS);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CW-1:0]        cnt_ff;
   logic [LEN_BITS-1:0]  rem_ff;
   logic [LEN_BITS-1:0]  dvs_ff;
   logic [TIME_BITS-1:0] q_ff;

   logic [LEN_BITS:0]    trial;
   logic [LEN_BITS:0]    diff;
   logic                 ge;
   logic [LEN_BITS-1:0]  rem_in;
   logic [TIME_BITS-1:0] q_in;

   // one compare and subtract step
   always_comb begin
      trial  = {rem_ff, q_ff[TIME_BITS-1]};
      diff   = trial - {1'b0, dvs_ff};
      ge     = (trial >= {1'b0, dvs_ff});
      rem_in = ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
      q_in   = {q_ff[TIME_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            q_ff    <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(TIME_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = rem_ff;

`ifndef SYNTH
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dvs_ff)) else $error("remainder not below divisor");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while still busy");
`endif

endmodule

>>> src/tdma_slot_frame_timekeeper.sv
`timescale 1ns / 1ps
// TDMA slot and frame timekeeper.
// One item at a time: a new item is taken only once the result of the last has been
// taken; the shared serial divider and multiply set the rate. A preamble that predates
// time zero takes one more divider run. Reset is synchronous and active high:
// unsynchronized, start, restart and idle times zero, registers at their reset values,
// no result pending.
module tdma_slot_frame_timekeeper import tsft_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [LEN_BITS-1:0]     csr_wdata,
   // items in
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [KIND_BITS-1:0]    req_kind,
   input  logic [TIME_BITS-1:0]    req_local_time,
   input  logic [TIME_BITS-1:0]    req_start_time,
   input  logic [TIME_BITS-1:0]    req_msg_timestamp,
   input  logic [LEN_BITS-1:0]     req_msg_offset,
   input  logic [TIME_BITS-1:0]    req_msg_network_age,
   input  logic [TIME_BITS-1:0]    req_query_time,
   input  logic [SLOT_BITS-1:0]    req_slot_query,
   // results out
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SLOT_BITS-1:0]    rsp_current_slot,
   output logic [TIME_BITS-1:0]    rsp_frame_number,
   output logic [LEN_BITS-1:0]     rsp_time_in_frame,
   output logic [LEN_BITS-1:0]     rsp_time_left_in_slot,
   output logic                    rsp_wait_over,
   output logic [SLOT_BITS-1:0]    rsp_slot_at_query,
   output logic signed [TIME_BITS+1:0] rsp_next_slot_start,
   output logic [TIME_BITS:0]      rsp_network_age_now,
   output logic [TIME_BITS-1:0]    rsp_last_idle_time,
   output logic                    rsp_synced
);

   localparam int CW     = $clog2(TIME_BITS);
   localparam int SW_BITS = LEN_BITS + SLOT_BITS;
   localparam int NXW    = ((TIME_BITS > SW_BITS) ? TIME_BITS : SW_BITS) + 2;

   typedef enum logic [2:0] {
      S_IDLE, S_ISSUE, S_WAIT, S_MUL, S_SUM, S_NXT, S_ADJ, S_OUT
   } state_type;

   typedef enum logic [2:0] {
      OP_PRE, OP_FRAME, OP_SLOT, OP_LEFT, OP_QFRM, OP_QSLOT, OP_SPF
   } op_type;

   state_type state_ff;
   op_type    op_ff;

   // configuration and timing state
   logic [LEN_BITS-1:0]  fl_ff, sl_ff, iw_ff;
   logic [TIME_BITS-1:0] fs_ff, wrt_ff, idle_ff;
   logic                 fsv_ff;

   // latched item
   logic [TIME_BITS-1:0] now_ff, ts_ff, age_ff, qt_ff;
   logic [LEN_BITS-1:0]  off_ff;
   logic [SLOT_BITS-1:0] sq_ff;

   // intermediate results
   logic [TIME_BITS-1:0] q1_ff;
   logic [LEN_BITS-1:0]  tif_ff, tls_ff, tifq_ff;
   logic [SLOT_BITS-1:0] slot_now_ff, slotq_ff;
   logic [TIME_BITS-1:0] prod_ff, mcand_ff, mplier_ff;
   logic [CW-1:0]        mcnt_ff;
   logic [SW_BITS-1:0]   sw_ff;
   logic [NXW-1:0]       nxt_ff;

   // result registers
   logic                 rsp_valid_ff;
   logic [SLOT_BITS-1:0] cur_slot_ff, slot_at_q_ff;
   logic [TIME_BITS-1:0] fnum_ff, last_idle_ff;
   logic [LEN_BITS-1:0]  tif_out_ff, tls_out_ff;
   logic                 wait_over_ff, synced_ff;
   logic [TIME_BITS+1:0] next_ff;
   logic [TIME_BITS:0]   age_now_ff;

   logic [LEN_BITS-1:0]  fl_eff, sl_eff;
   logic                 div_start, div_done;
   logic [TIME_BITS-1:0] div_dvd, div_quot;
   logic [LEN_BITS-1:0]  div_dvs, div_rem;
   logic [TIME_BITS-1:0] elapsed, q_elapsed;
   logic [NXW-1:0]       nxt_adj;
   logic [SLOT_BITS-1:0] sq_m1;
   logic [TIME_BITS:0]   wait_sum;

   assign fl_eff = eff_len(fl_ff);
   assign sl_eff = eff_len(sl_ff);
   assign elapsed   = (now_ff >= fs_ff) ? (now_ff - fs_ff) : '0;
   assign q_elapsed = (qt_ff >= fs_ff) ? (qt_ff - fs_ff) : '0;
   assign sq_m1     = (sq_ff == '0) ? '0 : (sq_ff - 8'd1);
   assign wait_sum  = (TIME_BITS+1)'(iw_ff) + (TIME_BITS+1)'(wrt_ff);
   assign nxt_adj   = (nxt_ff <= NXW'(now_ff)) ? (nxt_ff + NXW'(fl_eff)) : nxt_ff;

   // divider operand select
   always_comb begin
      div_dvd = elapsed;
      div_dvs = fl_eff;
      unique case (op_ff)
         OP_PRE:   div_dvd = TIME_BITS'(off_ff - ts_ff[LEN_BITS-1:0]);
         OP_FRAME: div_dvd = elapsed;
         OP_SLOT: begin
            div_dvd = TIME_BITS'(tif_ff);
            div_dvs = sl_eff;
         end
         OP_LEFT: begin
            div_dvd = now_ff - fs_ff;
            div_dvs = sl_eff;
         end
         OP_QFRM:  div_dvd = q_elapsed;
         OP_QSLOT: begin
            div_dvd = TIME_BITS'(tifq_ff);
            div_dvs = sl_eff;
         end
         OP_SPF: begin
            div_dvd = TIME_BITS'(fl_eff);
            div_dvs = sl_eff;
         end
         default: div_dvd = elapsed;
      endcase
   end

   assign div_start = (state_ff == S_ISSUE);

   tsft_div #(.TIME_BITS(TIME_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // sequencer, timing state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_FRAME;
         fl_ff        <= FRAME_LENGTH_RST;
         sl_ff        <= SLOT_LENGTH_RST;
         iw_ff        <= INITIAL_WAIT_RST;
         fs_ff        <= '0;
         fsv_ff       <= 1'b0;
         wrt_ff       <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_FRAME_LENGTH: fl_ff <= csr_wdata;
               CSR_SLOT_LENGTH:  sl_ff <= csr_wdata;
               CSR_INITIAL_WAIT: iw_ff <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  now_ff <= req_local_time;
                  ts_ff  <= req_msg_timestamp;
                  off_ff <= req_msg_offset;
                  age_ff <= req_msg_network_age;
                  qt_ff  <= req_query_time;
                  sq_ff  <= req_slot_query;
                  op_ff  <= OP_FRAME;
                  state_ff <= S_ISSUE;
                  case (req_kind)
                     KIND_SET_START: begin
                        fs_ff  <= req_start_time;
                        fsv_ff <= 1'b1;
                     end
                     KIND_PREAMBLE: begin
                        fsv_ff <= 1'b1;
                        if (req_msg_timestamp >= TIME_BITS'(req_msg_offset)) begin
                           fs_ff <= req_msg_timestamp - TIME_BITS'(req_msg_offset);
                        end else begin
                           op_ff <= OP_PRE;
                        end
                     end
                     KIND_RESTART: wrt_ff  <= req_local_time;
                     KIND_IDLE:    idle_ff <= req_local_time;
                     default: ;
                  endcase
               end
            end
            S_ISSUE: state_ff <= S_WAIT;
            S_WAIT: begin
               if (div_done) begin
                  state_ff <= S_ISSUE;
                  unique case (op_ff)
                     OP_PRE: begin
                        fs_ff <= (div_rem == '0) ? '0 : TIME_BITS'(fl_eff - div_rem);
                        op_ff <= OP_FRAME;
                     end
                     OP_FRAME: begin
                        q1_ff  <= div_quot;
                        tif_ff <= div_rem;
                        op_ff  <= OP_SLOT;
                     end
                     OP_SLOT: begin
                        slot_now_ff <= slot_sat(div_quot[LEN_BITS-1:0]);
                        op_ff       <= OP_LEFT;
                     end
                     OP_LEFT: begin
                        tls_ff <= div_rem;
                        op_ff  <= OP_QFRM;
                     end
                     OP_QFRM: begin
                        tifq_ff <= div_rem;
                        op_ff   <= OP_QSLOT;
                     end
                     OP_QSLOT: begin
                        slotq_ff <= slot_sat(div_quot[LEN_BITS-1:0]);
                        op_ff    <= OP_SPF;
                     end
                     OP_SPF: begin
                        // slots per frame times slot length
                        mcand_ff  <= TIME_BITS'(fl_eff - div_rem);
                        mplier_ff <= q1_ff;
                        prod_ff   <= '0;
                        mcnt_ff   <= '0;
                        state_ff  <= S_MUL;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_MUL: begin
               // shift-add multiply, product known to fit TIME_BITS
               if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
               mcand_ff  <= {mcand_ff[TIME_BITS-2:0], 1'b0};
               mplier_ff <= {1'b0, mplier_ff[TIME_BITS-1:1]};
               mcnt_ff   <= mcnt_ff + CW'(1);
               if (mcnt_ff == CW'(TIME_BITS - 1)) state_ff <= S_SUM;
            end
            S_SUM: begin
               sw_ff    <= SW_BITS'(sq_m1) * SW_BITS'(sl_eff);
               state_ff <= S_NXT;
            end
            S_NXT: begin
               nxt_ff   <= NXW'(fs_ff) + NXW'(prod_ff) + NXW'(sw_ff);
               state_ff <= S_ADJ;
            end
            S_ADJ: begin
               cur_slot_ff  <= fsv_ff ? slot_now_ff : 8'd1;
               fnum_ff      <= !fsv_ff ? '0 : ((&q1_ff) ? q1_ff : q1_ff + TIME_BITS'(1));
               tif_out_ff   <= fsv_ff ? tif_ff : '0;
               tls_out_ff   <= sl_eff - tls_ff;
               wait_over_ff <= ({1'b0, now_ff} >= wait_sum);
               slot_at_q_ff <= slotq_ff;
               next_ff      <= fsv_ff ? nxt_adj[TIME_BITS+1:0] : '1;
               age_now_ff   <= (TIME_BITS+1)'(age_ff) +
                               (TIME_BITS+1)'((now_ff >= ts_ff) ? (now_ff - ts_ff) : '0);
               last_idle_ff <= idle_ff;
               synced_ff    <= fsv_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign csr_ready             = 1'b1;
   assign req_ready             = (state_ff == S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_current_slot      = cur_slot_ff;
   assign rsp_frame_number      = fnum_ff;
   assign rsp_time_in_frame     = tif_out_ff;
   assign rsp_time_left_in_slot = tls_out_ff;
   assign rsp_wait_over         = wait_over_ff;
   assign rsp_slot_at_query     = slot_at_q_ff;
   assign rsp_next_slot_start   = next_ff;
   assign rsp_network_age_now   = age_now_ff;
   assign rsp_last_idle_time    = last_idle_ff;
   assign rsp_synced            = synced_ff;

`ifndef SYNTH
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready) else $error("input ready while a result waits");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_WAIT)) else $error("divider done outside wait");
   a_sync_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(fsv_ff) && !$past(reset) |-> fsv_ff) else $error("sync lost without reset");
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_OUT)) else $error("result valid outside output");
`endif

endmodule
